// ----- sv/oprs_pkg.sv -----
package oprs_pkg;

    // Input transaction kinds carried on s_axis_tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Panel command bytes
    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [7:0] CMD_LOW_OFFSET = 8'h02;
    localparam logic [7:0] CMD_LOW_PLAIN  = 8'h00;
    localparam logic [7:0] CMD_HIGH_COL   = 8'h10;

    // Header slots within one page
    localparam int HEADER_LEN   = 3;
    localparam int POS_PAGE_CMD = 0;
    localparam int POS_LOW_CMD  = 1;
    localparam int POS_HIGH_CMD = 2;

    // Sequencer status toward the control logic
    typedef struct packed {
        logic       active;
        logic       data_phase;
        logic       frame_end;
        logic       clearing;
        logic [7:0] cmd_byte;
    } seq_status_t;

endpackage

// ----- sv/oprs_ram.sv -----
module oprs_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds data when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/oprs_seq.sv -----
module oprs_seq
    import oprs_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8,
    parameter int ADDR_W  = $clog2(COLUMNS * PAGES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              arm,
    input  logic              arm_clear,
    input  logic              advance,
    input  logic              column_offset_mode,
    output seq_status_t       status,
    output logic [ADDR_W-1:0] addr
);

    localparam int POS_W = $clog2(COLUMNS + HEADER_LEN);
    localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W = $clog2(COLUMNS);

    logic             active_reg, active_next;
    logic             clear_reg, clear_next;
    logic [PG_W-1:0]  page_reg, page_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             data_phase;
    logic             end_of_page;
    logic             last_page;
    logic [COL_W-1:0] col;
    logic [7:0]       cmd_byte;

    // Decode the current slot
    assign data_phase  = pos_reg >= POS_W'(HEADER_LEN);
    assign end_of_page = pos_reg == POS_W'(HEADER_LEN + COLUMNS - 1);
    assign last_page   = page_reg == PG_W'(PAGES - 1);
    assign col         = COL_W'(pos_reg - POS_W'(HEADER_LEN));
    assign addr        = ADDR_W'(int'(page_reg) * COLUMNS + int'(col));

    // Pick the header command for this slot
    always_comb
    begin
        case (int'(pos_reg))
            POS_PAGE_CMD: cmd_byte = CMD_PAGE_BASE + 8'(page_reg);
            POS_LOW_CMD:  cmd_byte = column_offset_mode ? CMD_LOW_OFFSET : CMD_LOW_PLAIN;
            POS_HIGH_CMD: cmd_byte = CMD_HIGH_COL;
            default:      cmd_byte = 8'h00;
        endcase
    end

    assign status.active     = active_reg;
    assign status.data_phase = data_phase;
    assign status.frame_end  = end_of_page && last_page;
    assign status.clearing   = clear_reg;
    assign status.cmd_byte   = cmd_byte;

    // Arm from idle, advance one slot per emitted byte
    always_comb
    begin
        active_next = active_reg;
        clear_next  = clear_reg;
        page_next   = page_reg;
        pos_next    = pos_reg;
        if (!active_reg)
        begin
            if (arm)
            begin
                active_next = 1'b1;
                clear_next  = arm_clear;
                page_next   = '0;
                pos_next    = '0;
            end
        end
        else if (advance)
        begin
            if (end_of_page)
            begin
                pos_next = '0;
                if (last_page)
                begin
                    active_next = 1'b0;
                    clear_next  = 1'b0;
                    page_next   = '0;
                end
                else
                begin
                    page_next = page_reg + PG_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            clear_reg  <= 1'b0;
            page_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            clear_reg  <= clear_next;
            page_reg   <= page_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ----- sv/oled_page_refresh_sequencer_core.sv -----
// Page-mode refresh sequencer for a page-addressed monochrome panel.
// Input stream: s_axis_tuser carries the transaction kind (write column byte,
// start refresh, tick, clear and refresh); s_axis_tdata carries column, page
// and pixel byte for a write. Output stream: one panel byte per tick while a
// refresh runs, m_axis_tuser set for display data, m_axis_tlast on the final
// data byte of the frame. Each page sends three command bytes, then COLUMNS
// data bytes.
// Flow: writes, starts and command-byte ticks need no store read; a data-byte
// tick passes through the registered read of the frame store RAM and ST_FETCH.
// A clearing tick zeroes the entry and sends zero without a read.
// Reset: the frame store is swept to zero, one entry per cycle, across all
// COLUMNS*PAGES entries (1024 by default); s_axis_tready stays low meanwhile.
// cfg_we may write column_offset_mode at any time.
// Stall: the output register holds its byte while m_axis_tready is low; a tick
// that would emit is held off until the register frees, other transactions
// still go through.
module oled_page_refresh_sequencer_core
    import oprs_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column[6:0], page[9:7], pixels[17:10], zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // panel_byte[7:0]
    output logic        m_axis_tuser,   // data_flag[0]
    output logic        m_axis_tlast
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_ctr_reg, clr_ctr_next;
    logic              offset_mode_reg;
    logic              last_hold_reg, last_hold_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_flag_reg, out_flag_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [6:0]        in_column;
    logic [2:0]        in_page;
    logic [7:0]        in_pixels;
    logic [1:0]        in_opcode;
    logic              in_accept;
    logic              produces;
    logic              wr_in_range;
    logic              load_direct;
    logic              start_fetch;

    seq_status_t       status;
    logic [ADDR_W-1:0] seq_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // Unpack the input transaction
    assign in_column = s_axis_tdata[6:0];
    assign in_page   = s_axis_tdata[9:7];
    assign in_pixels = s_axis_tdata[17:10];
    assign in_opcode = s_axis_tuser;

    // Accept while idle; an emitting tick needs the output register free
    assign produces      = (in_opcode == OP_TICK) && status.active;
    assign s_axis_tready = (state_reg == ST_IDLE)
                           && (!produces || !out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign wr_in_range = (int'(in_column) < COLUMNS) && (int'(in_page) < PAGES);
    assign load_direct = in_accept && produces
                         && (!status.data_phase || status.clearing);
    assign start_fetch = in_accept && produces
                         && status.data_phase && !status.clearing;

    oprs_seq #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk                (clk),
        .rst_n              (rst_n),
        .arm                (in_accept && ((in_opcode == OP_START) || (in_opcode == OP_CLEAR))),
        .arm_clear          (in_opcode == OP_CLEAR),
        .advance            (in_accept && produces),
        .column_offset_mode (offset_mode_reg),
        .status             (status),
        .addr               (seq_addr)
    );

    // Select the single write port source
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = seq_addr;
        ram_wdata = 8'h00;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_ctr_reg;
        end
        else if (in_accept && (in_opcode == OP_WRITE) && wr_in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(int'(in_page) * COLUMNS + int'(in_column));
            ram_wdata = in_pixels;
        end
        else if (load_direct && status.data_phase)
        begin
            ram_we = 1'b1;
        end
    end

    oprs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (start_fetch),
        .raddr (seq_addr),
        .rdata (ram_rdata)
    );

    // Control: clearing sweep, idle, wait for store read
    always_comb
    begin
        state_next     = state_reg;
        clr_ctr_next   = clr_ctr_reg;
        last_hold_next = last_hold_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_ctr_next = clr_ctr_reg + ADDR_W'(1);
                if (clr_ctr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start_fetch)
                begin
                    state_next     = ST_FETCH;
                    last_hold_next = status.frame_end;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a byte, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_direct)
        begin
            out_valid_next = 1'b1;
            out_flag_next  = status.data_phase;
            out_byte_next  = status.cmd_byte;
            out_last_next  = status.frame_end;
        end
        else if (state_reg == ST_FETCH)
        begin
            out_valid_next = 1'b1;
            out_flag_next  = 1'b1;
            out_byte_next  = ram_rdata;
            out_last_next  = last_hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_ctr_reg     <= '0;
            offset_mode_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ctr_reg   <= clr_ctr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                offset_mode_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_hold_reg <= last_hold_next;
        out_flag_reg  <= out_flag_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

    // A store read always lands in the output register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (m_axis_tvalid && m_axis_tuser))
        else $error("fetched data byte not presented");

    // The output register is free while a read is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !out_valid_reg)
        else $error("read completed into a full output register");

    // No transaction is taken during the reset sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during store sweep");

    // End of frame is marked only on a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end on a command byte");

    // The sequencer stops after the final byte of the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && produces && status.frame_end) |=> !status.active)
        else $error("sequencer still active after frame end");

endmodule
